>>> rtl/tct_pkg.sv
// -----------------------------------------------------------------------------
// tct_pkg: shared definitions for the text console teletype
// Screen geometry, field widths, character codes, opcodes and FSM states.
// -----------------------------------------------------------------------------
package tct_pkg;

	// Screen geometry
	localparam int ROWS  = 25;
	localparam int COLS  = 80;
	localparam int CELLS = ROWS * COLS;

	// Item field widths
	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int ROW_W    = 5;
	localparam int COLUMN_W = 7;
	localparam int CURPOS_W = 11;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	// Internal widths
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int CUR_W   = $clog2(CELLS + 1);
	localparam int COL_W   = $clog2(COLS);
	localparam int IDX_MAX = ((1 << ROW_W) - 1) * COLS + ((1 << COLUMN_W) - 1);
	localparam int IDX_W   = $clog2(((IDX_MAX > CELLS) ? IDX_MAX : CELLS) + 1);

	// Character codes
	localparam logic [CHAR_W-1:0] PRINT_LOW    = 8'd32;
	localparam logic [CHAR_W-1:0] PRINT_HIGH   = 8'd126;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd0;

	// Attribute after reset
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

	typedef enum logic [OP_W-1:0] {
		OP_TTY   = 2'd0,
		OP_WRITE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_PUT,
		ST_READ
	} state_t;

endpackage

>>> rtl/tct_if.sv
// -----------------------------------------------------------------------------
// tct_if: valid/ready channels of the text console teletype
// Command channel, response channel and attribute write channel.
// -----------------------------------------------------------------------------
interface tct_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [tct_pkg::OP_W-1:0]         opcode;
	logic [tct_pkg::CHAR_W-1:0]       char_code;
	logic [tct_pkg::ROW_W-1:0]        row;
	logic [tct_pkg::COLUMN_W-1:0]     column;
	logic [tct_pkg::ATTR_W-1:0]       cell_attribute;

	modport source (output valid, opcode, char_code, row, column, cell_attribute,
		input ready);
	modport sink (input valid, opcode, char_code, row, column, cell_attribute,
		output ready);
endinterface

interface tct_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [tct_pkg::CURPOS_W-1:0]     cursor_position;
	logic [tct_pkg::CHAR_W-1:0]       read_char;
	logic [tct_pkg::ATTR_W-1:0]       read_attr;

	modport source (output valid, cursor_position, read_char, read_attr, input ready);
	modport sink (input valid, cursor_position, read_char, read_attr, output ready);
endinterface

interface tct_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tct_pkg::ATTR_W-1:0]       default_attribute;

	modport source (output valid, default_attribute, input ready);
	modport sink (input valid, default_attribute, output ready);
endinterface

>>> rtl/tct_ram.sv
// -----------------------------------------------------------------------------
// tct_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module tct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/text_console_teletype.sv
// -----------------------------------------------------------------------------
// text_console_teletype: character cell screen with teletype output and scroll
// Cells live in one RAM of {char, attr}; a sequencer does writes, reads,
// scroll (copy up one row, blank bottom row) and clear sweeps.
//
//   channel | role | content
//   --------+------+---------------------------------------------------------
//   cmd     | in   | opcode, char_code, row, column, cell_attribute
//   rsp     | out  | cursor_position, read_char, read_attr (one per cmd item)
//   cfg     | in   | default_attribute, always ready
//
// Teletype print/newline and cell write complete from IDLE; a cell read passes
// through READ for the registered RAM read. Teletype with the cursor at screen
// end: a scroll sweep through the single RAM port pair, then the put. Clear:
// a sweep that blanks every cell with the default attribute.
// After arst_n the RAM is swept to blanks, all CELLS (2000) cells; cmd is
// not ready meanwhile. cmd is taken while the response register is empty or
// is being drained; a stalled rsp holds the next item off.
// -----------------------------------------------------------------------------
module text_console_teletype (
	input  logic         clk,
	input  logic         arst_n,
	tct_cmd_if.sink      cmd,
	tct_rsp_if.source    rsp,
	tct_cfg_if.sink      cfg
);

	localparam int CELLS  = tct_pkg::CELLS;
	localparam int COLS   = tct_pkg::COLS;
	localparam int ADDR_W = tct_pkg::ADDR_W;
	localparam int CUR_W  = tct_pkg::CUR_W;
	localparam int COL_W  = tct_pkg::COL_W;
	localparam int IDX_W  = tct_pkg::IDX_W;
	localparam int CHAR_W = tct_pkg::CHAR_W;
	localparam int ATTR_W = tct_pkg::ATTR_W;
	localparam int CELL_W = tct_pkg::CELL_W;

	tct_pkg::state_t state_q, state_d;

	logic [CUR_W-1:0]  cursor_q, cursor_d;
	logic [CUR_W-1:0]  base_q, base_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [CUR_W-1:0]  cnt_q, cnt_d;
	logic [ATTR_W-1:0] def_attr_q;
	logic [ATTR_W-1:0] clr_attr_q, clr_attr_d;
	logic              clr_rsp_q, clr_rsp_d;
	logic [CHAR_W-1:0] code_q;
	logic              idx_ok_q;

	logic              rsp_valid_q;
	logic [CUR_W-1:0]  rsp_cursor_q;
	logic [CHAR_W-1:0] rsp_char_q, rsp_char_d;
	logic [ATTR_W-1:0] rsp_attr_q, rsp_attr_d;
	logic              load_rsp;
	logic              latch;
	logic              cmd_ready;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;

	logic [IDX_W-1:0]  idx;
	logic              idx_ok;
	logic [CHAR_W-1:0] code_sel;
	logic              tt_print, tt_nl;

	// cell RAM
	tct_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// linear cell index of the command
	assign idx    = IDX_W'(cmd.row) * IDX_W'(COLS) + IDX_W'(cmd.column);
	assign idx_ok = idx < IDX_W'(CELLS);

	// teletype code decode
	assign code_sel = (state_q == tct_pkg::ST_PUT) ? code_q : cmd.char_code;
	assign tt_print = (code_sel >= tct_pkg::PRINT_LOW) && (code_sel <= tct_pkg::PRINT_HIGH);
	assign tt_nl    = (code_sel == tct_pkg::NEWLINE_CODE);

	// sequencer: next state, RAM access, cursor update
	always_comb begin
		state_d    = state_q;
		cursor_d   = cursor_q;
		base_d     = base_q;
		col_d      = col_q;
		cnt_d      = cnt_q;
		clr_attr_d = clr_attr_q;
		clr_rsp_d  = clr_rsp_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		load_rsp   = 1'b0;
		rsp_char_d = '0;
		rsp_attr_d = '0;
		cmd_ready  = 1'b0;
		latch      = 1'b0;

		case (state_q)
			tct_pkg::ST_IDLE: begin
				cmd_ready = !rsp_valid_q || rsp.ready;
				if (cmd.valid && cmd_ready) begin
					latch = 1'b1;
					case (tct_pkg::opcode_t'(cmd.opcode))
						tct_pkg::OP_TTY: begin
							if (cursor_q == CUR_W'(CELLS)) begin
								// screen full: scroll first, char follows in PUT
								cursor_d = CUR_W'(CELLS - COLS);
								base_d   = CUR_W'(CELLS - COLS);
								col_d    = '0;
								cnt_d    = '0;
								state_d  = tct_pkg::ST_SCROLL;
							end else begin
								load_rsp = 1'b1;
								if (tt_print) begin
									mem_we    = 1'b1;
									mem_waddr = ADDR_W'(cursor_q);
									mem_wdata = {code_sel, def_attr_q};
									cursor_d  = cursor_q + CUR_W'(1);
									if (col_q == COL_W'(COLS - 1)) begin
										col_d  = '0;
										base_d = base_q + CUR_W'(COLS);
									end else begin
										col_d = col_q + COL_W'(1);
									end
								end else if (tt_nl) begin
									cursor_d = base_q + CUR_W'(COLS);
									base_d   = base_q + CUR_W'(COLS);
									col_d    = '0;
								end
							end
						end
						tct_pkg::OP_WRITE: begin
							load_rsp  = 1'b1;
							mem_we    = idx_ok;
							mem_waddr = ADDR_W'(idx);
							mem_wdata = {cmd.char_code, cmd.cell_attribute};
						end
						tct_pkg::OP_CLEAR: begin
							cursor_d   = '0;
							base_d     = '0;
							col_d      = '0;
							cnt_d      = '0;
							clr_attr_d = def_attr_q;
							clr_rsp_d  = 1'b1;
							state_d    = tct_pkg::ST_CLEAR;
						end
						tct_pkg::OP_READ: begin
							mem_re    = idx_ok;
							mem_raddr = ADDR_W'(idx);
							state_d   = tct_pkg::ST_READ;
						end
						default: begin
							load_rsp = 1'b1;
						end
					endcase
				end
			end
			tct_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cnt_q);
				mem_wdata = {tct_pkg::BLANK_CHAR, clr_attr_q};
				if (cnt_q == CUR_W'(CELLS - 1)) begin
					load_rsp  = clr_rsp_q;
					clr_rsp_d = 1'b0;
					state_d   = tct_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + CUR_W'(1);
				end
			end
			tct_pkg::ST_SCROLL: begin
				// read one row ahead, write back the cell read last cycle
				if (cnt_q < CUR_W'(CELLS - COLS)) begin
					mem_re    = 1'b1;
					mem_raddr = ADDR_W'(cnt_q + CUR_W'(COLS));
				end
				if (cnt_q != '0) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(cnt_q - CUR_W'(1));
					mem_wdata = (cnt_q <= CUR_W'(CELLS - COLS)) ? mem_rdata :
						{tct_pkg::BLANK_CHAR, def_attr_q};
				end
				if (cnt_q == CUR_W'(CELLS)) begin
					state_d = tct_pkg::ST_PUT;
				end else begin
					cnt_d = cnt_q + CUR_W'(1);
				end
			end
			tct_pkg::ST_PUT: begin
				// cursor sits at the start of the bottom row here
				load_rsp = 1'b1;
				state_d  = tct_pkg::ST_IDLE;
				if (tt_print) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(cursor_q);
					mem_wdata = {code_sel, def_attr_q};
					cursor_d  = cursor_q + CUR_W'(1);
					col_d     = col_q + COL_W'(1);
				end else if (tt_nl) begin
					cursor_d = base_q + CUR_W'(COLS);
					base_d   = base_q + CUR_W'(COLS);
					col_d    = '0;
				end
			end
			tct_pkg::ST_READ: begin
				load_rsp = 1'b1;
				state_d  = tct_pkg::ST_IDLE;
				if (idx_ok_q) begin
					rsp_char_d = mem_rdata[CELL_W-1:ATTR_W];
					rsp_attr_d = mem_rdata[ATTR_W-1:0];
				end
			end
			default: begin
				state_d = tct_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tct_pkg::ST_CLEAR;
			cursor_q   <= '0;
			base_q     <= '0;
			col_q      <= '0;
			cnt_q      <= '0;
			clr_attr_q <= tct_pkg::RESET_ATTR;
			clr_rsp_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cursor_q   <= cursor_d;
			base_q     <= base_d;
			col_q      <= col_d;
			cnt_q      <= cnt_d;
			clr_attr_q <= clr_attr_d;
			clr_rsp_q  <= clr_rsp_d;
		end
	end

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_attr_q <= tct_pkg::RESET_ATTR;
		end else if (cfg.valid) begin
			def_attr_q <= cfg.default_attribute;
		end
	end

	// item fields kept for the later states
	always_ff @(posedge clk) begin
		if (latch) begin
			code_q   <= cmd.char_code;
			idx_ok_q <= idx_ok;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_cursor_q <= cursor_d;
			rsp_char_q   <= rsp_char_d;
			rsp_attr_q   <= rsp_attr_d;
		end
	end

	assign cmd.ready           = cmd_ready;
	assign cfg.ready           = 1'b1;
	assign rsp.valid           = rsp_valid_q;
	assign rsp.cursor_position = tct_pkg::CURPOS_W'(rsp_cursor_q);
	assign rsp.read_char       = rsp_char_q;
	assign rsp.read_attr       = rsp_attr_q;

	// checks
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_W'(CELLS))
		else $error("cursor beyond screen end");

	a_cursor_split: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q == base_q + CUR_W'(col_q))
		else $error("cursor does not match row base plus column");

	a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |-> (!rsp_valid_q || rsp.ready))
		else $error("response register overwritten while stalled");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CUR_W'(mem_waddr) < CUR_W'(CELLS)))
		else $error("cell write outside screen");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tct_pkg::ST_SCROLL) |-> (cursor_q == CUR_W'(CELLS - COLS)))
		else $error("cursor not on bottom row during scroll");

endmodule

>>> tb/tb_text_console_teletype.sv
// -----------------------------------------------------------------------------
// tb_text_console_teletype: self-checking bench for the text console teletype
// Keeps a shadow copy of the screen, cursor and default attribute and predicts
// the reply to every command item. A directed table covers reset contents,
// off-screen and wrapped addresses, ignored codes, scroll and clear. Random
// phases follow, each under its own default attribute, with random gaps
// and stalls on both channels.
// -----------------------------------------------------------------------------
module tb_text_console_teletype;

	localparam int ROWS     = tct_pkg::ROWS;
	localparam int COLS     = tct_pkg::COLS;
	localparam int CELLS    = tct_pkg::CELLS;
	localparam int CHAR_W   = tct_pkg::CHAR_W;
	localparam int ATTR_W   = tct_pkg::ATTR_W;
	localparam int ROW_W    = tct_pkg::ROW_W;
	localparam int COLUMN_W = tct_pkg::COLUMN_W;
	localparam int CURPOS_W = tct_pkg::CURPOS_W;

	localparam int STALL_LIMIT     = 10000;	// idle cycles before giving up
	localparam int SETTLE_CYCLES   = 50;
	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 260;
	localparam int DIRECTED_ROWS   = 27;

	typedef struct packed {
		tct_pkg::opcode_t    op;
		logic [CHAR_W-1:0]   code;
		logic [ROW_W-1:0]    row;
		logic [COLUMN_W-1:0] column;
		logic [ATTR_W-1:0]   attr;
	} console_cmd_t;

	typedef struct packed {
		logic [CURPOS_W-1:0] cursor;
		logic [CHAR_W-1:0]   ch;
		logic [ATTR_W-1:0]   at;
	} console_reply_t;

	typedef struct packed {
		console_cmd_t   cmd;
		logic [5:0]     reps;
		logic           typed;
		console_reply_t reply;
	} directed_row_t;

	// Directed items; rows with typed set carry their reply, the rest are predicted
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{tct_pkg::OP_READ, 8'h00, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h07}},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd31, 7'd127, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd24, 7'd79, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h07}},
		'{'{tct_pkg::OP_WRITE, 8'hFF, 5'd24, 7'd79, 8'hFF}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd24, 7'd79, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'hFF, 8'hFF}},
		'{'{tct_pkg::OP_WRITE, 8'h41, 5'd0, 7'd80, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd1, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h41, 8'h00}},
		'{'{tct_pkg::OP_WRITE, 8'h55, 5'd24, 7'd80, 8'hAA}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd24, 7'd80, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_TTY, 8'd32, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd1, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_TTY, 8'd126, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd2, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_TTY, 8'd31, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd2, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_TTY, 8'd127, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd2, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_TTY, 8'd255, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd2, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd0, 7'd1, 8'h00}, 6'd1, 1'b1, '{11'd2, 8'h7E, 8'h07}},
		'{'{tct_pkg::OP_TTY, 8'd10, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd80, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_TTY, 8'd65, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b0, '0},
		// newlines run the cursor to the screen end
		'{'{tct_pkg::OP_TTY, 8'd10, 5'd0, 7'd0, 8'h00}, 6'd24, 1'b0, '0},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd24, 7'd79, 8'h00}, 6'd1, 1'b0, '0},
		// ignored code still scrolls first
		'{'{tct_pkg::OP_TTY, 8'd0, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b0, '0},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd23, 7'd79, 8'h00}, 6'd1, 1'b0, '0},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd24, 7'd79, 8'h00}, 6'd1, 1'b0, '0},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b0, '0},
		// newline on the bottom row lands on the screen end
		'{'{tct_pkg::OP_TTY, 8'd10, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b0, '0},
		'{'{tct_pkg::OP_TTY, 8'd90, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b0, '0},
		'{'{tct_pkg::OP_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h00}},
		'{'{tct_pkg::OP_READ, 8'h00, 5'd0, 7'd0, 8'h00}, 6'd1, 1'b1, '{11'd0, 8'h00, 8'h07}}
	};

	logic clk;
	logic arst_n;

	tct_cmd_if cmd_ch ();
	tct_rsp_if rsp_ch ();
	tct_cfg_if cfg_ch ();

	text_console_teletype DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow screen state
	logic [CHAR_W-1:0] screen_char [CELLS];
	logic [ATTR_W-1:0] screen_attr [CELLS];
	int                cursor_at;
	logic [ATTR_W-1:0] default_attr;

	console_reply_t awaited_replies [$];
	int             mismatches = 0;
	bit             cmd_calm = 1'b0;
	bit             rsp_calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void blank_cells(input int from, input int upto);
		int i;
		for (i = from; i < upto; i++) begin
			screen_char[i] = tct_pkg::BLANK_CHAR;
			screen_attr[i] = default_attr;
		end
	endfunction

	// Apply one command item to the shadow screen and return its reply
	function automatic console_reply_t apply_command(input console_cmd_t c);
		console_reply_t r;
		int idx;
		int i;
		r = '0;
		idx = int'(c.row) * COLS + int'(c.column);
		case (c.op)
			tct_pkg::OP_TTY: begin
				if (cursor_at >= CELLS) begin
					for (i = 0; i < CELLS - COLS; i++) begin
						screen_char[i] = screen_char[i + COLS];
						screen_attr[i] = screen_attr[i + COLS];
					end
					blank_cells(CELLS - COLS, CELLS);
					cursor_at -= COLS;
				end
				if (c.code >= tct_pkg::PRINT_LOW && c.code <= tct_pkg::PRINT_HIGH) begin
					screen_char[cursor_at] = c.code;
					screen_attr[cursor_at] = default_attr;
					cursor_at++;
				end else if (c.code == tct_pkg::NEWLINE_CODE) begin
					cursor_at = COLS * (1 + cursor_at / COLS);
				end
			end
			tct_pkg::OP_WRITE: begin
				if (idx < CELLS) begin
					screen_char[idx] = c.code;
					screen_attr[idx] = c.attr;
				end
			end
			tct_pkg::OP_CLEAR: begin
				blank_cells(0, CELLS);
				cursor_at = 0;
			end
			default: begin
				if (idx < CELLS) begin
					r.ch = screen_char[idx];
					r.at = screen_attr[idx];
				end
			end
		endcase
		r.cursor = CURPOS_W'(cursor_at);
		return r;
	endfunction

	// Wait before the next item; calm stretches have no wait at all
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// Drive one command item; called and returning at a rising edge
	task automatic send_command(input console_cmd_t c, input logic typed,
			input console_reply_t typed_reply);
		int gap;
		console_reply_t r;
		gap = draw_wait(cmd_calm);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.opcode         <= c.op;
		cmd_ch.char_code      <= c.code;
		cmd_ch.row            <= c.row;
		cmd_ch.column         <= c.column;
		cmd_ch.cell_attribute <= c.attr;
		@(negedge clk);
		while (cmd_ch.ready !== 1'b1) @(negedge clk);
		r = apply_command(c);
		awaited_replies.push_back(typed ? typed_reply : r);
		@(posedge clk);
	endtask

	task automatic write_default_attr(input logic [ATTR_W-1:0] value);
		cfg_ch.valid             <= 1'b1;
		cfg_ch.default_attribute <= value;
		@(negedge clk);
		while (cfg_ch.ready !== 1'b1) @(negedge clk);
		default_attr = value;
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stimulus
	initial begin
		console_cmd_t      c;
		logic [ATTR_W-1:0] attr_list [4];
		int                p;
		int                n;
		int                k;
		int                sel;
		attr_list = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
		arst_n                   <= 1'b0;
		cmd_ch.valid             <= 1'b0;
		cmd_ch.opcode            <= tct_pkg::OP_TTY;
		cmd_ch.char_code         <= '0;
		cmd_ch.row               <= '0;
		cmd_ch.column            <= '0;
		cmd_ch.cell_attribute    <= '0;
		cfg_ch.valid             <= 1'b0;
		cfg_ch.default_attribute <= tct_pkg::RESET_ATTR;
		default_attr = tct_pkg::RESET_ATTR;
		blank_cells(0, CELLS);
		cursor_at = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (n = 0; n < DIRECTED_ROWS; n++) begin
			for (k = 0; k < int'(DIRECTED[n].reps); k++)
				send_command(DIRECTED[n].cmd, DIRECTED[n].typed, DIRECTED[n].reply);
		end

		// Random phases, each under its own default attribute
		for (p = 0; p < PHASES; p++) begin
			cmd_ch.valid <= 1'b0;
			while (awaited_replies.size() != 0) @(posedge clk);
			write_default_attr((p < 4) ? attr_list[p] : ATTR_W'($urandom));
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				c.code   = CHAR_W'($urandom);
				c.column = COLUMN_W'($urandom);
				c.attr   = ATTR_W'($urandom);
				c.row    = ($urandom_range(0, 6) == 0) ? ROW_W'($urandom)
					: ROW_W'($urandom_range(0, ROWS - 1));
				sel = $urandom_range(0, 99);
				if (sel < 48) begin
					// mostly printable text and newlines, some other codes
					c.op = tct_pkg::OP_TTY;
					k = $urandom_range(0, 9);
					if (k < 6)
						c.code = CHAR_W'($urandom_range(tct_pkg::PRINT_LOW,
							tct_pkg::PRINT_HIGH));
					else if (k < 8)
						c.code = tct_pkg::NEWLINE_CODE;
				end else if (sel < 68) begin
					c.op = tct_pkg::OP_WRITE;
				end else if (sel < 70) begin
					c.op = tct_pkg::OP_CLEAR;
				end else begin
					c.op = tct_pkg::OP_READ;
				end
				send_command(c, 1'b0, '0);
			end
		end

		cmd_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Reply channel back-pressure
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait(rsp_calm);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(negedge clk);
			while (rsp_ch.valid !== 1'b1) @(negedge clk);
			@(posedge clk);
		end
	end

	// Reply checker: handshake seen mid-cycle is taken at the next edge
	initial begin
		console_reply_t want;
		console_reply_t got;
		forever begin
			@(negedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = '{rsp_ch.cursor_position, rsp_ch.read_char, rsp_ch.read_attr};
				if (awaited_replies.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected reply: cursor %0d char %h attr %h",
						$time, got.cursor, got.ch, got.at);
				end else begin
					want = awaited_replies.pop_front();
					if (got.cursor !== want.cursor) begin
						mismatches++;
						$display("%0t: cursor_position expected %0d actual %0d",
							$time, want.cursor, got.cursor);
					end
					if (got.ch !== want.ch) begin
						mismatches++;
						$display("%0t: read_char expected %h actual %h",
							$time, want.ch, got.ch);
					end
					if (got.at !== want.at) begin
						mismatches++;
						$display("%0t: read_attr expected %h actual %h",
							$time, want.at, got.at);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no item moving on any channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
					(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
rtl/tct_pkg.sv
rtl/tct_if.sv
rtl/tct_ram.sv
rtl/text_console_teletype.sv
tb/tb_text_console_teletype.sv
